FILE: sv/rpgb_pkg.sv
// rpgb_pkg: pixel type, kernel weights, divisor and per-channel filter function
// for the RGB five-tap blur. No dependencies.
`timescale 1ns / 1ps

package rpgb_pkg;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  localparam int unsigned Taps        = 5;
  localparam int unsigned WinDepth    = 4;
  localparam int unsigned HalfWindow  = 2;
  localparam int unsigned PosLimit    = 4;
  localparam int unsigned NormDivisor = 1;
  // a divisor of zero behaves as one
  localparam int unsigned NormDiv     = (NormDivisor == 0) ? 1 : NormDivisor;
  localparam int unsigned Rounding    = 127;

  // reciprocal of the divisor; exact floor for any 17-bit sum and divisor up to 256
  localparam int unsigned RecipShift  = 25;
  localparam logic [25:0] NormRecip   =
      26'(((64'd1 << RecipShift) + 64'(NormDiv) - 64'd1) / 64'(NormDiv));

  localparam logic [6:0] KernelW [Taps] = '{7'd16, 7'd62, 7'd99, 7'd62, 7'd16};

  typedef logic [7:0] tap_vec_t [Taps];

  function automatic logic [7:0] blur_chan(input tap_vec_t taps);
    logic [16:0] acc;
    logic [42:0] prod;
    logic [16:0] quo;
    logic [16:0] rnd;
    logic [8:0]  shr;
    acc = '0;
    for (int t = 0; t < Taps; t++) begin
      acc = acc + 17'(taps[t]) * 17'(KernelW[t]);
    end
    prod = 43'(acc) * 43'(NormRecip);
    quo  = prod[41:25];
    rnd = quo + 17'(Rounding);
    shr = rnd[16:8];
    if (shr > 9'd255) begin
      return 8'hff;
    end
    return shr[7:0];
  endfunction

endpackage

FILE: sv/rgb_pixel_gaussian_blur_top.sv
// Five-tap Gaussian blur over an RGB pixel stream (16, 62, 99, 62, 16).
// Throughput is one pixel per clock while the output accepts. Each result is
// centred two pixels behind the newest input; neighbours outside the frame read as
// zero. A pixel flagged with frame_end_i releases up to three results (two pending
// centres and itself), one per clock through the single output register while the
// output accepts; the input stalls on that pixel until the last of them enters the
// output register. An input transfer reaches the result through a tap-snapshot
// register, then the filter and the output register. Depends on rpgb_pkg.
`timescale 1ns / 1ps

module rgb_pixel_gaussian_blur_top
  import rpgb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] pixel_red_i,
  input  logic [7:0] pixel_green_i,
  input  logic [7:0] pixel_blue_i,
  input  logic       frame_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] blurred_red_o,
  output logic [7:0] blurred_green_o,
  output logic [7:0] blurred_blue_o,
  output logic       final_pixel_o
);

  pixel_t       win_q [WinDepth];
  logic [2:0]   pos_q;

  logic         hold_valid_q;
  pixel_t       hold_px_q [Taps];
  logic [1:0]   hold_idx_q;
  logic [1:0]   hold_last_q;
  logic         hold_end_q;

  logic         out_valid_q;
  logic [7:0]   out_r_q, out_g_q, out_b_q;
  logic         out_final_q;

  pixel_t       cur;
  logic         out_free;
  logic         hold_done;
  logic         in_xfer;
  logic         gen;
  logic [1:0]   lo_idx;
  pixel_t       ext [Taps + HalfWindow];
  tap_vec_t     tap_r, tap_g, tap_b;

  always_comb begin
    cur       = '{r: pixel_red_i, g: pixel_green_i, b: pixel_blue_i};
    out_free  = !out_valid_q || out_ready_i;
    hold_done = hold_valid_q && out_free && (hold_idx_q == hold_last_q);
    in_ready_o = !hold_valid_q || hold_done;
    in_xfer   = in_valid_i && in_ready_o;
    gen       = frame_end_i || (pos_q >= 3'd2);
    unique case (pos_q)
      3'd0:    lo_idx = 2'd2;
      3'd1:    lo_idx = 2'd1;
      default: lo_idx = 2'd0;
    endcase
  end

  // taps of the current centre, zeros past the last pixel
  always_comb begin
    for (int i = 0; i < Taps; i++) begin
      ext[i] = hold_px_q[i];
    end
    for (int i = Taps; i < Taps + HalfWindow; i++) begin
      ext[i] = '0;
    end
    for (int i = 0; i < Taps; i++) begin
      unique case (hold_idx_q)
        2'd0:    begin tap_r[i] = ext[i].r;     tap_g[i] = ext[i].g;     tap_b[i] = ext[i].b;     end
        2'd1:    begin tap_r[i] = ext[i + 1].r; tap_g[i] = ext[i + 1].g; tap_b[i] = ext[i + 1].b; end
        2'd2:    begin tap_r[i] = ext[i + 2].r; tap_g[i] = ext[i + 2].g; tap_b[i] = ext[i + 2].b; end
        default: begin tap_r[i] = '0;           tap_g[i] = '0;           tap_b[i] = '0;           end
      endcase
    end
  end

  // pixel window and frame position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WinDepth; i++) begin
        win_q[i] <= '0;
      end
      pos_q <= '0;
    end else if (in_xfer) begin
      if (frame_end_i) begin
        for (int i = 0; i < WinDepth; i++) begin
          win_q[i] <= '0;
        end
        pos_q <= '0;
      end else begin
        win_q[0] <= cur;
        for (int i = 1; i < WinDepth; i++) begin
          win_q[i] <= win_q[i - 1];
        end
        if (pos_q < 3'(PosLimit)) begin
          pos_q <= pos_q + 3'd1;
        end
      end
    end
  end

  // snapshot control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      hold_idx_q   <= '0;
      hold_last_q  <= '0;
      hold_end_q   <= 1'b0;
    end else if (in_xfer && gen) begin
      hold_valid_q <= 1'b1;
      hold_idx_q   <= lo_idx;
      hold_last_q  <= frame_end_i ? 2'd2 : 2'd0;
      hold_end_q   <= frame_end_i;
    end else if (hold_done) begin
      hold_valid_q <= 1'b0;
    end else if (hold_valid_q && out_free) begin
      hold_idx_q <= hold_idx_q + 2'd1;
    end
  end

  // snapshot taps, oldest first
  always_ff @(posedge clk_i) begin
    if (in_xfer && gen) begin
      hold_px_q[0] <= win_q[3];
      hold_px_q[1] <= win_q[2];
      hold_px_q[2] <= win_q[1];
      hold_px_q[3] <= win_q[0];
      hold_px_q[4] <= cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (hold_valid_q && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_valid_q && out_free) begin
      out_r_q     <= blur_chan(tap_r);
      out_g_q     <= blur_chan(tap_g);
      out_b_q     <= blur_chan(tap_b);
      out_final_q <= hold_end_q && (hold_idx_q == hold_last_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign blurred_red_o   = out_r_q;
  assign blurred_green_o = out_g_q;
  assign blurred_blue_o  = out_b_q;
  assign final_pixel_o   = out_final_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= 3'(PosLimit))
    else $error("frame position beyond limit");

  a_idx_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid_q |-> hold_idx_q <= hold_last_q)
    else $error("centre index past last centre");

  a_in_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && hold_valid_q) |-> (out_free && hold_idx_q == hold_last_q))
    else $error("transfer accepted over pending centres");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && frame_end_i) |=> (pos_q == 3'd0 && hold_valid_q))
    else $error("frame end did not flush");

  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_valid_q && out_free && hold_idx_q != hold_last_q) |=> !final_pixel_o)
    else $error("final marker before last centre");

endmodule

FILE: tb/sv/rgb_pixel_gaussian_blur_chk.sv
// rgb_pixel_gaussian_blur_chk: watches the input and output sides of the blur, predicts the filtered
// pixels of each frame and compares every output transfer with them.
// Depends on rpgb_pkg (pixel type, divisor).
`timescale 1ns / 1ps

module rgb_pixel_gaussian_blur_chk
  import rpgb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] pixel_red_i,
  input  logic [7:0] pixel_green_i,
  input  logic [7:0] pixel_blue_i,
  input  logic       frame_end_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] blurred_red_i,
  input  logic [7:0] blurred_green_i,
  input  logic [7:0] blurred_blue_i,
  input  logic       final_pixel_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         results_seen_o
);

  typedef struct packed {
    pixel_t px;
    logic   last;
  } blurred_px_t;

  localparam int unsigned GaussW [5] = '{16, 62, 99, 62, 16};
  localparam int unsigned BlurDiv = (NormDivisor == 0) ? 1 : NormDivisor;

  pixel_t      recent_px [4];
  int unsigned frame_count;
  blurred_px_t expected_px [$];

  assign pending_o = expected_px.size();

  function automatic logic [7:0] gauss_level(input logic [7:0] v0, input logic [7:0] v1,
                                             input logic [7:0] v2, input logic [7:0] v3,
                                             input logic [7:0] v4);
    int unsigned sum;
    sum = v0 * GaussW[0] + v1 * GaussW[1] + v2 * GaussW[2] + v3 * GaussW[3] + v4 * GaussW[4];
    sum = (sum / BlurDiv + 127) >> 8;
    return (sum > 255) ? 8'hff : sum[7:0];
  endfunction

  task automatic predict_pixel(input pixel_t cur, input logic last);
    pixel_t      taps [7];
    blurred_px_t res;
    int unsigned lo;
    int unsigned hi;
    taps[0] = recent_px[3];
    taps[1] = recent_px[2];
    taps[2] = recent_px[1];
    taps[3] = recent_px[0];
    taps[4] = cur;
    taps[5] = '0;
    taps[6] = '0;
    // centre k is frame pixel (count - 4 + k); only existing pixels are centres
    lo = 4 - frame_count;
    if (lo < 2) begin
      lo = 2;
    end
    hi = last ? 4 : 2;
    for (int unsigned k = lo; k <= hi; k++) begin
      res.px.r = gauss_level(taps[k-2].r, taps[k-1].r, taps[k].r, taps[k+1].r, taps[k+2].r);
      res.px.g = gauss_level(taps[k-2].g, taps[k-1].g, taps[k].g, taps[k+1].g, taps[k+2].g);
      res.px.b = gauss_level(taps[k-2].b, taps[k-1].b, taps[k].b, taps[k+1].b, taps[k+2].b);
      res.last = last && (k == hi);
      expected_px.push_back(res);
    end
    if (last) begin
      foreach (recent_px[i]) recent_px[i] = '0;
      frame_count = 0;
    end else begin
      recent_px[3] = recent_px[2];
      recent_px[2] = recent_px[1];
      recent_px[1] = recent_px[0];
      recent_px[0] = cur;
      if (frame_count < 4) begin
        frame_count++;
      end
    end
  endtask

  task automatic check_result();
    blurred_px_t exp_px;
    results_seen_o++;
    if (expected_px.size() == 0) begin
      $error("unexpected result transfer: r=%0d g=%0d b=%0d final=%0b",
             blurred_red_i, blurred_green_i, blurred_blue_i, final_pixel_i);
      fail_count_o++;
      return;
    end
    exp_px = expected_px.pop_front();
    if (blurred_red_i !== exp_px.px.r) begin
      $error("blurred_red: expected %0d, got %0d", exp_px.px.r, blurred_red_i);
      fail_count_o++;
    end
    if (blurred_green_i !== exp_px.px.g) begin
      $error("blurred_green: expected %0d, got %0d", exp_px.px.g, blurred_green_i);
      fail_count_o++;
    end
    if (blurred_blue_i !== exp_px.px.b) begin
      $error("blurred_blue: expected %0d, got %0d", exp_px.px.b, blurred_blue_i);
      fail_count_o++;
    end
    if (final_pixel_i !== exp_px.last) begin
      $error("final_pixel: expected %0b, got %0b", exp_px.last, final_pixel_i);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o   = 0;
    results_seen_o = 0;
  end

  // results leave through the snapshot and output registers, so compare before predicting
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (recent_px[i]) recent_px[i] = '0;
      frame_count = 0;
      expected_px.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_result();
      end
      if (in_valid_i && in_ready_i) begin
        predict_pixel('{r: pixel_red_i, g: pixel_green_i, b: pixel_blue_i}, frame_end_i);
      end
    end
  end

endmodule

FILE: tb/sv/rgb_pixel_gaussian_blur_top_tb.sv
// rgb_pixel_gaussian_blur_top_tb: drives directed and random pixel frames into the blur
// with random idling on both sides and one long output hold-off, then gives the verdict.
// Depends on rgb_pixel_gaussian_blur_top, rgb_pixel_gaussian_blur_chk and rpgb_pkg.
`timescale 1ns / 1ps

module rgb_pixel_gaussian_blur_top_tb;

  localparam int CycleLimit  = 600000;
  localparam int TargetItems = 450;
  localparam int HoldStart   = 150;
  localparam int HoldCycles  = 300;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] pixel_red_i;
  logic [7:0] pixel_green_i;
  logic [7:0] pixel_blue_i;
  logic       frame_end_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] blurred_red_o;
  logic [7:0] blurred_green_o;
  logic [7:0] blurred_blue_o;
  logic       final_pixel_o;

  int fail_count;
  int pending;
  int results_seen;
  int pixels_sent;
  int frames_sent;
  int cycles;
  bit burst_mode;
  bit hold_off;

  rgb_pixel_gaussian_blur_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_red_i    (pixel_red_i),
    .pixel_green_i  (pixel_green_i),
    .pixel_blue_i   (pixel_blue_i),
    .frame_end_i    (frame_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .blurred_red_o  (blurred_red_o),
    .blurred_green_o(blurred_green_o),
    .blurred_blue_o (blurred_blue_o),
    .final_pixel_o  (final_pixel_o)
  );

  rgb_pixel_gaussian_blur_chk u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .pixel_red_i    (pixel_red_i),
    .pixel_green_i  (pixel_green_i),
    .pixel_blue_i   (pixel_blue_i),
    .frame_end_i    (frame_end_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .blurred_red_i  (blurred_red_o),
    .blurred_green_i(blurred_green_o),
    .blurred_blue_i (blurred_blue_o),
    .final_pixel_i  (final_pixel_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_seen_o (results_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int idle_len();
    int sel;
    if (burst_mode) begin
      return 0;
    end
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    if (sel < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_level();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return 8'h00;
    if (sel < 30) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic last);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_red_i   <= r;
    pixel_green_i <= g;
    pixel_blue_i  <= b;
    frame_end_i   <= last;
    do @(posedge clk_i); while (!in_ready_o);
    pixels_sent++;
    if (last) begin
      frames_sent++;
    end
  endtask

  task automatic send_frame(input int len, input int style);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (style)
        0: begin
          r = 8'hff; g = 8'hff; b = 8'hff;
        end
        1: begin
          r = 8'h00; g = 8'h00; b = 8'h00;
        end
        2: begin
          r = (i % 2) ? 8'haa : 8'h55;
          g = (i % 2) ? 8'h55 : 8'haa;
          b = 8'(8'h01 << (i % 8));
        end
        default: begin
          r = pick_level(); g = pick_level(); b = pick_level();
        end
      endcase
      send_pixel(r, g, b, i == len - 1);
    end
  endtask

  // receiver: random stalls, plus the long hold-off
  initial begin
    int stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = idle_len();
      end
    end
  end

  initial begin
    hold_off = 1'b0;
    wait (pixels_sent >= HoldStart);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timed out with %0d results outstanding", pending);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    cycles        = 0;
    pixels_sent   = 0;
    frames_sent   = 0;
    burst_mode    = 1'b0;
    in_valid_i    = 1'b0;
    pixel_red_i   = '0;
    pixel_green_i = '0;
    pixel_blue_i  = '0;
    frame_end_i   = 1'b0;
    rst_ni        = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: one- and two-pixel frames, short frames, extremes and bit patterns
    send_frame(1, 0);
    send_frame(2, 2);
    send_frame(3, 3);
    send_frame(4, 1);
    send_frame(6, 0);
    send_frame(5, 2);

    while (pixels_sent < TargetItems) begin
      int sel;
      int len;
      burst_mode = ($urandom_range(0, 99) < 20);
      sel = $urandom_range(0, 99);
      if (sel < 70) len = $urandom_range(1, 8);
      else if (sel < 95) len = $urandom_range(9, 20);
      else len = $urandom_range(30, 60);
      send_frame(len, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : 3);
    end
    burst_mode = 1'b0;
    in_valid_i <= 1'b0;

    // let the checker take the last transfer before looking at the backlog
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Blur run: %0d pixels in %0d frames, %0d filtered pixels checked",
             pixels_sent, frames_sent, results_seen);
    $display("Frames of one pixel up to sixty, random idling and a long output hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/rpgb_pkg.sv
sv/rgb_pixel_gaussian_blur_top.sv
tb/sv/rgb_pixel_gaussian_blur_chk.sv
tb/sv/rgb_pixel_gaussian_blur_top_tb.sv
